FILE: src/positional_ordered_list_unit_defines.svh
// Assertion macros shared by the positional ordered list unit.
// Needs a clock named clk and a reset named rst in the including module.
`ifndef POSITIONAL_ORDERED_LIST_UNIT_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define POL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("positional ordered list: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define POL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("positional ordered list: next-cycle check failed");

`endif

FILE: src/pol_pkg.sv
// Shared types and codes for the positional ordered list unit.
// No dependencies; used by the cell, the controller and the top level.
package pol_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic [2:0] action_t;
  localparam action_t ACT_INS_FRONT = 3'd0;
  localparam action_t ACT_INS_END   = 3'd1;
  localparam action_t ACT_INS_AT    = 3'd2;
  localparam action_t ACT_DEL_FRONT = 3'd3;
  localparam action_t ACT_DEL_END   = 3'd4;
  localparam action_t ACT_DEL_AT    = 3'd5;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

  typedef logic [1:0] cell_op_t;
  localparam cell_op_t OP_HOLD = 2'd0;
  localparam cell_op_t OP_INS  = 2'd1;
  localparam cell_op_t OP_DEL  = 2'd2;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    cell_op_t            op;
    logic [DATA_W-1:0]   value;
  } cell_cmd_t;

endpackage

FILE: src/pol_cell.sv
// One storage cell of the list row: holds one entry, shifts with its neighbors.
// Depends on pol_pkg.
module pol_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                        clk,
  input  pol_pkg::cell_cmd_t          cmd,
  input  logic [CNT_W-1:0]            pos,
  input  logic [pol_pkg::DATA_W-1:0]  left_value,
  input  logic [pol_pkg::DATA_W-1:0]  right_value,
  output logic [pol_pkg::DATA_W-1:0]  value
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [pol_pkg::DATA_W-1:0] value_next;

  always_comb begin
    value_next = value;
    case (cmd.op)
      pol_pkg::OP_INS: begin
        // take from the left above the slot, load the new item at the slot
        if (MY_IDX > pos) begin
          value_next = left_value;
        end else if (MY_IDX == pos) begin
          value_next = cmd.value;
        end
      end
      pol_pkg::OP_DEL: begin
        if (MY_IDX >= pos) begin
          value_next = right_value;
        end
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

FILE: src/pol_ctrl.sv
// Controller of the list: occupancy count, request decode, output register.
// Depends on pol_pkg and positional_ordered_list_unit_defines.svh.
`include "positional_ordered_list_unit_defines.svh"

module pol_ctrl #(
  parameter int CAPACITY = 16,
  parameter int CNT_W    = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  pol_pkg::action_t                  action,
  input  logic signed [pol_pkg::DATA_W-1:0] value,
  input  logic [CNT_W-1:0]                  position,
  input  logic [pol_pkg::DATA_W-1:0]        sel_value,
  output pol_pkg::cell_cmd_t                cmd,
  output logic [CNT_W-1:0]                  cmd_pos,
  output logic                              out_valid,
  input  logic                              out_stall,
  output pol_pkg::status_t                  status,
  output logic signed [pol_pkg::DATA_W-1:0] removed_value,
  output logic [CNT_W-1:0]                  count
);

  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

  logic [CNT_W-1:0]           occupancy;
  logic [CNT_W-1:0]           occupancy_next;
  logic                       out_valid_next;
  logic                       accept;
  logic                       full;
  logic                       empty;
  pol_pkg::cell_op_t          dec_op;
  pol_pkg::status_t           dec_status;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (occupancy == CAP);
  assign empty    = (occupancy == '0);

  always_comb begin
    dec_op     = pol_pkg::OP_HOLD;
    dec_status = pol_pkg::ST_OK;
    cmd_pos    = '0;
    case (action)
      pol_pkg::ACT_INS_FRONT: begin
        if (full) begin
          dec_status = pol_pkg::ST_FULL;
        end else begin
          dec_op = pol_pkg::OP_INS;
        end
      end
      pol_pkg::ACT_INS_END: begin
        cmd_pos = occupancy;
        if (full) begin
          dec_status = pol_pkg::ST_FULL;
        end else begin
          dec_op = pol_pkg::OP_INS;
        end
      end
      pol_pkg::ACT_INS_AT: begin
        cmd_pos = position;
        if (position > occupancy) begin
          dec_status = pol_pkg::ST_RANGE;
        end else if (full) begin
          dec_status = pol_pkg::ST_FULL;
        end else begin
          dec_op = pol_pkg::OP_INS;
        end
      end
      pol_pkg::ACT_DEL_FRONT: begin
        if (empty) begin
          dec_status = pol_pkg::ST_EMPTY;
        end else begin
          dec_op = pol_pkg::OP_DEL;
        end
      end
      pol_pkg::ACT_DEL_END: begin
        cmd_pos = occupancy - ONE;
        if (empty) begin
          dec_status = pol_pkg::ST_EMPTY;
        end else begin
          dec_op = pol_pkg::OP_DEL;
        end
      end
      pol_pkg::ACT_DEL_AT: begin
        cmd_pos = position;
        if (empty && position == '0) begin
          dec_status = pol_pkg::ST_EMPTY;
        end else if (position >= occupancy) begin
          dec_status = pol_pkg::ST_RANGE;
        end else begin
          dec_op = pol_pkg::OP_DEL;
        end
      end
      default: begin
        dec_op     = pol_pkg::OP_HOLD;
        dec_status = pol_pkg::ST_OK;
      end
    endcase
  end

  // Cells move only on an accepted item.
  assign cmd.op    = accept ? dec_op : pol_pkg::OP_HOLD;
  assign cmd.value = value;

  always_comb begin
    occupancy_next = occupancy;
    if (cmd.op == pol_pkg::OP_INS) begin
      occupancy_next = occupancy + ONE;
    end else if (cmd.op == pol_pkg::OP_DEL) begin
      occupancy_next = occupancy - ONE;
    end
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (accept) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      occupancy <= occupancy_next;
      out_valid <= out_valid_next;
    end
  end

  // Result payload: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= dec_status;
      count         <= occupancy_next;
      removed_value <= (dec_op == pol_pkg::OP_DEL) ? $signed(sel_value) : '0;
    end
  end

  `POL_ASSERT_IMPL(a_occ_bound, 1'b1, occupancy <= CAP)
  `POL_ASSERT_NEXT(a_ins_grows, cmd.op == pol_pkg::OP_INS, occupancy == $past(occupancy) + ONE)
  `POL_ASSERT_NEXT(a_del_shrinks, cmd.op == pol_pkg::OP_DEL, occupancy == $past(occupancy) - ONE)
  `POL_ASSERT_IMPL(a_fail_no_value, out_valid && status != pol_pkg::ST_OK, removed_value == '0)
  `POL_ASSERT_NEXT(a_count_tracks, accept, count == occupancy)

endmodule

FILE: src/positional_ordered_list_unit.sv
// Positional ordered list unit: bounded ordered list with positional insert and delete.
// An accepted item's result is loaded into the output register in the next cycle.
// Throughput: one item per cycle; input stalls only while a result waits under out_stall.
// Every cell of the row shifts in the same cycle, so each item completes in one pass.
// Reset clears the occupancy and the output valid; stored entries and the result payload are not cleared.
// Depends on pol_pkg, pol_cell and pol_ctrl.
module positional_ordered_list_unit #(
  parameter int CAPACITY = 16,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        action,
  input  logic signed [31:0]                value,
  input  logic [CNT_W-1:0]                  position,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic signed [31:0]                removed_value,
  output logic [CNT_W-1:0]                  count
);

  pol_pkg::cell_cmd_t           cmd;
  logic [CNT_W-1:0]             cmd_pos;
  logic [pol_pkg::DATA_W-1:0]   cell_value [CAPACITY];
  logic [pol_pkg::DATA_W-1:0]   sel_value;

  pol_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .value         (value),
    .position      (position),
    .sel_value     (sel_value),
    .cmd           (cmd),
    .cmd_pos       (cmd_pos),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .removed_value (removed_value),
    .count         (count)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [pol_pkg::DATA_W-1:0] left_value;
    logic [pol_pkg::DATA_W-1:0] right_value;

    // front cell never takes from the left; end cell takes zero on a delete
    if (i == 0) begin : g_front
      assign left_value = cmd.value;
    end else begin : g_mid_l
      assign left_value = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_value = '0;
    end else begin : g_mid_r
      assign right_value = cell_value[i+1];
    end

    pol_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .pos         (cmd_pos),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (cell_value[i])
    );
  end

  // Pick the entry at the command position for the removed value.
  always_comb begin
    sel_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd_pos == CNT_W'(i)) begin
        sel_value = sel_value | cell_value[i];
      end
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for positional_ordered_list_unit: directed corner items, then random items.
// A tracker class mirrors the list and checks every result; depends on pol_pkg and the unit.
module tb_top;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = 5;

  // Codes the unit treats as no-ops.
  localparam pol_pkg::action_t ACT_SPARE_6 = 3'd6;
  localparam pol_pkg::action_t ACT_SPARE_7 = 3'd7;

  typedef struct {
    pol_pkg::status_t   status;
    logic signed [31:0] removed_value;
    logic [CNT_W-1:0]   count;
  } list_result_t;

  class ordered_list_tracker;
    logic signed [31:0] held[$];
    list_result_t       awaited[$];
    int unsigned        failures;

    function void note_request(pol_pkg::action_t act, logic signed [31:0] val,
                               logic [CNT_W-1:0] pos);
      list_result_t r;
      r.status        = pol_pkg::ST_OK;
      r.removed_value = '0;
      case (act)
        pol_pkg::ACT_INS_FRONT, pol_pkg::ACT_INS_END, pol_pkg::ACT_INS_AT: begin
          if (act == pol_pkg::ACT_INS_AT && pos > held.size()) r.status = pol_pkg::ST_RANGE;
          else if (held.size() >= CAPACITY) r.status = pol_pkg::ST_FULL;
          else if (act == pol_pkg::ACT_INS_FRONT) held.push_front(val);
          else if (act == pol_pkg::ACT_INS_END) held.push_back(val);
          else held.insert(pos, val);
        end
        pol_pkg::ACT_DEL_FRONT: begin
          if (held.size() == 0) r.status = pol_pkg::ST_EMPTY;
          else r.removed_value = held.pop_front();
        end
        pol_pkg::ACT_DEL_END: begin
          if (held.size() == 0) r.status = pol_pkg::ST_EMPTY;
          else r.removed_value = held.pop_back();
        end
        pol_pkg::ACT_DEL_AT: begin
          if (held.size() == 0 && pos == '0) r.status = pol_pkg::ST_EMPTY;
          else if (pos >= held.size()) r.status = pol_pkg::ST_RANGE;
          else begin
            r.removed_value = held[pos];
            held.delete(pos);
          end
        end
        default: ;
      endcase
      r.count = CNT_W'(held.size());
      awaited.push_back(r);
    endfunction

    function void check_result(pol_pkg::status_t st, logic signed [31:0] removed,
                               logic [CNT_W-1:0] cnt);
      list_result_t r;
      if (awaited.size() == 0) begin
        $error("result with nothing pending: status %0d removed_value %0d count %0d",
               st, removed, cnt);
        failures++;
        return;
      end
      r = awaited.pop_front();
      if (st !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, st);
        failures++;
      end
      if (removed !== r.removed_value) begin
        $error("removed_value: expected %0d, actual %0d", r.removed_value, removed);
        failures++;
      end
      if (cnt !== r.count) begin
        $error("count: expected %0d, actual %0d", r.count, cnt);
        failures++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [2:0]               action = '0;
  logic signed [31:0]       value = '0;
  logic [CNT_W-1:0]         position = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               status;
  logic signed [31:0]       removed_value;
  logic [CNT_W-1:0]         count;

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned sender_plan[5];
  int unsigned receiver_plan[5];

  ordered_list_tracker tracker = new;

  positional_ordered_list_unit #(.CAPACITY(CAPACITY)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .value         (value),
    .position      (position),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .removed_value (removed_value),
    .count         (count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_result(status, removed_value, count);
  end

  // Offer one item, idling first at the current rate, and record it once taken.
  task automatic send_item(pol_pkg::action_t act, logic signed [31:0] val,
                           logic [CNT_W-1:0] pos);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(act, val, pos);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_item(int unsigned insert_pct);
    pol_pkg::action_t   ins_ops[3] = '{pol_pkg::ACT_INS_FRONT, pol_pkg::ACT_INS_END,
                                       pol_pkg::ACT_INS_AT};
    pol_pkg::action_t   del_ops[3] = '{pol_pkg::ACT_DEL_FRONT, pol_pkg::ACT_DEL_END,
                                       pol_pkg::ACT_DEL_AT};
    logic signed [31:0] corners[4] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sh1};
    pol_pkg::action_t   act;
    logic signed [31:0] val;
    logic [CNT_W-1:0]   pos;
    int unsigned        n;
    int unsigned        pick;
    n    = tracker.held.size();
    pick = $urandom_range(99);
    if (pick < 2) act = $urandom_range(1) ? ACT_SPARE_7 : ACT_SPARE_6;
    else if (pick < insert_pct) act = ins_ops[$urandom_range(2)];
    else act = del_ops[$urandom_range(2)];
    // Keep most positions near the live range so both valid and range cases appear.
    if ($urandom_range(9) < 8) pos = CNT_W'($urandom_range(n > 15 ? 16 : n + 1));
    else pos = CNT_W'($urandom_range(16));
    val = ($urandom_range(9) == 0) ? corners[$urandom_range(3)] : $urandom;
    send_item(act, val, pos);
  endtask

  initial begin
    int unsigned insert_pct;
    sender_plan   = '{0, 70, 0, 25, 0};
    receiver_plan = '{0, 0, 70, 25, 0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Empty list corners.
    send_item(pol_pkg::ACT_DEL_FRONT, 32'sh0, 5'd0);
    send_item(pol_pkg::ACT_DEL_END, 32'sh0, 5'd0);
    send_item(pol_pkg::ACT_DEL_AT, 32'sh0, 5'd0);
    send_item(pol_pkg::ACT_DEL_AT, 32'sh0, 5'd5);
    send_item(pol_pkg::ACT_INS_AT, 32'sh1234, 5'd1);
    send_item(ACT_SPARE_7, 32'sh5678, 5'd3);
    // Each insert kind, append through insert at position equal to count.
    send_item(pol_pkg::ACT_INS_FRONT, 32'sh8000_0000, 5'd0);
    send_item(pol_pkg::ACT_INS_END, 32'sh7FFF_FFFF, 5'd0);
    send_item(pol_pkg::ACT_INS_AT, 32'sh0, 5'd1);
    send_item(pol_pkg::ACT_INS_AT, -32'sh1, 5'd3);
    send_item(pol_pkg::ACT_DEL_AT, 32'sh0, 5'd4);
    send_item(pol_pkg::ACT_DEL_AT, 32'sh0, 5'd1);
    send_item(ACT_SPARE_6, 32'sh0, 5'd0);
    // Fill to capacity, then push against the full list.
    for (int i = 0; i < 13; i++) begin
      if (i % 2) send_item(pol_pkg::ACT_INS_END, 32'sh1 << (i + 16), 5'd0);
      else send_item(pol_pkg::ACT_INS_AT, 32'shA5A5_0000 | i, CNT_W'(1 + i));
    end
    send_item(pol_pkg::ACT_INS_FRONT, 32'sh55, 5'd0);
    send_item(pol_pkg::ACT_INS_AT, 32'sh66, 5'd16);
    send_item(pol_pkg::ACT_DEL_AT, 32'sh0, 5'd15);
    send_item(pol_pkg::ACT_DEL_FRONT, 32'sh0, 5'd0);
    send_item(pol_pkg::ACT_DEL_END, 32'sh0, 5'd0);
    wait_for_results();

    for (int ph = 0; ph < 5; ph++) begin
      sender_idle_pct    = sender_plan[ph];
      receiver_stall_pct = receiver_plan[ph];
      insert_pct         = 50;
      for (int i = 0; i < 190; i++) begin
        // Swing between filling and draining so both full and empty get reached.
        if (i % 32 == 0) insert_pct = $urandom_range(80, 20);
        send_random_item(insert_pct);
      end
      wait_for_results();
    end

    repeat (5) @(posedge clk);
    if (tracker.failures == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
